FILE: src/msalu_pkg.sv
// Shared types and opcode constants for the MIPS subset execute block.
package msalu_pkg;

  localparam int NUM_REGS  = 32;
  localparam int REG_IDX_W = 5;
  localparam int INSN_W    = 32;
  localparam int IMM_W     = 16;
  localparam int SHAMT_W   = 5;
  localparam int OUT_VAL_W = 16;

  // Primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_ANDI  = 6'h0C;
  localparam logic [5:0] OPC_ORI   = 6'h0D;

  // R-type function codes
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_SLL,
    ALU_SRA,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_ADDI,
    ALU_ANDI,
    ALU_ORI
  } alu_op_e;

  // Decoded instruction as it travels from front to back
  typedef struct packed {
    alu_op_e              op;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] dst;
    logic [SHAMT_W-1:0]   shamt;
    logic [IMM_W-1:0]     imm;
  } dec_t;

  // One result word
  typedef struct packed {
    logic                 wrote;
    logic [REG_IDX_W-1:0] dest_index;
    logic [OUT_VAL_W-1:0] dest_value;
  } res_t;

endpackage

FILE: src/msalu_ram.sv
// Generic RAM: one write port, two registered read ports.
module msalu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/msalu_fifo.sv
// Small register FIFO used for the decode queue and the result queue.
module msalu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/msalu_front.sv
// Front end: split an instruction word into fields and classify the operation.
module msalu_front (
  input  logic [msalu_pkg::INSN_W-1:0] instruction_word_i,
  output msalu_pkg::dec_t              dec_o
);

  logic [5:0] opcode;
  logic [5:0] funct;

  assign opcode = instruction_word_i[31:26];
  assign funct  = instruction_word_i[5:0];

  always_comb begin
    dec_o.rs    = instruction_word_i[25:21];
    dec_o.rt    = instruction_word_i[20:16];
    dec_o.shamt = instruction_word_i[10:6];
    dec_o.imm   = instruction_word_i[15:0];
    dec_o.op    = msalu_pkg::ALU_NONE;
    if (opcode == msalu_pkg::OPC_RTYPE) begin
      dec_o.dst = instruction_word_i[15:11];
      case (funct)
        msalu_pkg::FN_SLL: dec_o.op = msalu_pkg::ALU_SLL;
        msalu_pkg::FN_SRA: dec_o.op = msalu_pkg::ALU_SRA;
        msalu_pkg::FN_ADD: dec_o.op = msalu_pkg::ALU_ADD;
        msalu_pkg::FN_SUB: dec_o.op = msalu_pkg::ALU_SUB;
        msalu_pkg::FN_AND: dec_o.op = msalu_pkg::ALU_AND;
        msalu_pkg::FN_OR:  dec_o.op = msalu_pkg::ALU_OR;
        msalu_pkg::FN_NOR: dec_o.op = msalu_pkg::ALU_NOR;
        default:           dec_o.op = msalu_pkg::ALU_NONE;
      endcase
    end else begin
      dec_o.dst = instruction_word_i[20:16];
      case (opcode)
        msalu_pkg::OPC_ADDI: dec_o.op = msalu_pkg::ALU_ADDI;
        msalu_pkg::OPC_ANDI: dec_o.op = msalu_pkg::ALU_ANDI;
        msalu_pkg::OPC_ORI:  dec_o.op = msalu_pkg::ALU_ORI;
        default:             dec_o.op = msalu_pkg::ALU_NONE;
      endcase
    end
  end

endmodule

FILE: src/msalu_back.sv
// Back end: register file read, execute, write back and result queue.
module msalu_back #(
  parameter int REG_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  msalu_pkg::dec_t q_head_i,
  output logic            q_pop_o,
  output msalu_pkg::res_t res_o,
  output logic            res_empty_o,
  input  logic            res_pop_i
);

  localparam int IW  = msalu_pkg::REG_IDX_W;
  localparam int EXW = REG_WIDTH + msalu_pkg::IMM_W;

  msalu_pkg::dec_t     e_item_q;
  logic                e_valid_q;
  logic                e_fire, e_load;
  msalu_pkg::dec_t     rd_item;

  logic [REG_WIDTH-1:0] ram_a, ram_b;
  logic [msalu_pkg::NUM_REGS-1:0] vld_q;
  logic                 vld_a_q, vld_b_q;
  logic                 byp_valid_q;
  logic [IW-1:0]        byp_idx_q;
  logic [REG_WIDTH-1:0] byp_val_q;

  logic [REG_WIDTH-1:0] opnd_a, opnd_b, alu_res;
  logic [EXW-1:0]       imm_sx_wide, imm_zx_wide, res_wide;
  logic [REG_WIDTH-1:0] imm_sx, imm_zx;
  logic                 wr;
  logic                 we;
  logic                 res_full;
  msalu_pkg::res_t      res_word;

  // Execute stage advances when the result queue has room
  assign e_fire  = e_valid_q && !res_full;
  assign e_load  = !e_valid_q || e_fire;
  assign q_pop_o = e_load && !q_empty_i;

  // Read addresses follow the item that sits in execute next cycle
  assign rd_item = e_load ? q_head_i : e_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      vld_q       <= '0;
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      if (e_load) begin
        e_valid_q <= !q_empty_i;
      end
      if (we) begin
        vld_q[e_item_q.dst] <= 1'b1;
      end
      vld_a_q     <= vld_q[rd_item.rs];
      vld_b_q     <= vld_q[rd_item.rt];
      byp_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      e_item_q <= q_head_i;
    end
    if (we) begin
      byp_idx_q <= e_item_q.dst;
      byp_val_q <= alu_res;
    end
  end

  msalu_ram #(
    .WIDTH(REG_WIDTH),
    .DEPTH(msalu_pkg::NUM_REGS)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (e_item_q.dst),
    .wdata_i  (alu_res),
    .raddr_a_i(rd_item.rs),
    .raddr_b_i(rd_item.rt),
    .rdata_a_o(ram_a),
    .rdata_b_o(ram_b)
  );

  // Forward the write of the last edge; never-written registers read zero
  always_comb begin
    if (byp_valid_q && byp_idx_q == e_item_q.rs) begin
      opnd_a = byp_val_q;
    end else begin
      opnd_a = vld_a_q ? ram_a : '0;
    end
    if (byp_valid_q && byp_idx_q == e_item_q.rt) begin
      opnd_b = byp_val_q;
    end else begin
      opnd_b = vld_b_q ? ram_b : '0;
    end
  end

  assign imm_sx_wide = {{REG_WIDTH{e_item_q.imm[msalu_pkg::IMM_W-1]}}, e_item_q.imm};
  assign imm_zx_wide = {{REG_WIDTH{1'b0}}, e_item_q.imm};
  assign imm_sx      = imm_sx_wide[REG_WIDTH-1:0];
  assign imm_zx      = imm_zx_wide[REG_WIDTH-1:0];

  // Shifts of REG_WIDTH or more saturate to zero or sign fill by operator rules
  always_comb begin
    wr      = 1'b1;
    alu_res = '0;
    case (e_item_q.op)
      msalu_pkg::ALU_SLL:  alu_res = opnd_b << e_item_q.shamt;
      msalu_pkg::ALU_SRA:  alu_res = $unsigned($signed(opnd_b) >>> e_item_q.shamt);
      msalu_pkg::ALU_ADD:  alu_res = opnd_a + opnd_b;
      msalu_pkg::ALU_SUB:  alu_res = opnd_a - opnd_b;
      msalu_pkg::ALU_AND:  alu_res = opnd_a & opnd_b;
      msalu_pkg::ALU_OR:   alu_res = opnd_a | opnd_b;
      msalu_pkg::ALU_NOR:  alu_res = ~(opnd_a | opnd_b);
      msalu_pkg::ALU_ADDI: alu_res = opnd_a + imm_sx;
      msalu_pkg::ALU_ANDI: alu_res = opnd_a & imm_zx;
      msalu_pkg::ALU_ORI:  alu_res = opnd_a | imm_zx;
      default:             wr = 1'b0;
    endcase
  end

  assign we       = e_fire && wr;
  assign res_wide = {{msalu_pkg::IMM_W{1'b0}}, alu_res};

  always_comb begin
    res_word.wrote      = wr;
    res_word.dest_index = wr ? e_item_q.dst : '0;
    res_word.dest_value = wr ? res_wide[msalu_pkg::OUT_VAL_W-1:0] : '0;
  end

  msalu_fifo #(
    .WIDTH($bits(msalu_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (e_fire),
    .wdata_i(res_word),
    .full_o (res_full),
    .pop_i  (res_pop_i),
    .rdata_o(res_o),
    .empty_o(res_empty_o)
  );

endmodule

FILE: src/mips_subset_alu_regfile_unit.sv
// Top level of the MIPS subset ALU and register file execute block.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------
//   insn     | in        | push, full           | instruction_word_i[31:0]
//   result   | out       | empty, pop           | wrote_register_o, dest_index_o[4:0],
//            |           |                      | dest_value_o[15:0]
//
// One word a cycle sustained in both directions while results are popped; the
// execute stage, with its single register-file write port, sets that figure. A
// pushed word reaches the result ports through the decode queue, then execute.
// Reset clears the valid bits, so every register reads zero at once; no clearing pass.
// A stalled result side fills the two-word result queue, then holds execute,
// then fills the two-word decode queue before full rises.
module mips_subset_alu_regfile_unit #(
  parameter int REG_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_word_i,
  output logic        empty,
  input  logic        pop,
  output logic        wrote_register_o,
  output logic [4:0]  dest_index_o,
  output logic [15:0] dest_value_o
);

  msalu_pkg::dec_t dec;
  msalu_pkg::dec_t q_head;
  logic            q_empty;
  logic            q_pop;
  msalu_pkg::res_t res;

  // Decode the incoming word
  msalu_front u_front (
    .instruction_word_i(instruction_word_i),
    .dec_o             (dec)
  );

  // Decouple decode from execute
  msalu_fifo #(
    .WIDTH($bits(msalu_pkg::dec_t)),
    .DEPTH(2)
  ) u_dec_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(dec),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_head),
    .empty_o(q_empty)
  );

  // Execute and write back
  msalu_back #(
    .REG_WIDTH(REG_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .res_o      (res),
    .res_empty_o(empty),
    .res_pop_i  (pop)
  );

  assign wrote_register_o = res.wrote;
  assign dest_index_o     = res.dest_index;
  assign dest_value_o     = res.dest_value;

endmodule

FILE: src/msalu_checker.sv
// Port-level checker for the execute block, bound to the top level.
module msalu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        wrote_register_o,
  input logic [4:0]  dest_index_o,
  input logic [15:0] dest_value_o
);

  // A word that wrote nothing carries zero index and value
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !wrote_register_o) |-> (dest_index_o == '0 && dest_value_o == '0))
    else $error("result without write has nonzero fields");

  // The decode queue only fills when the result side is backed up
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("input full while no result is waiting");

  // Leaving reset, nothing is queued on either side
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(wrote_register_o) &&
                          $stable(dest_index_o) && $stable(dest_value_o)))
    else $error("waiting result changed or vanished");

endmodule

bind mips_subset_alu_regfile_unit msalu_checker u_checker (.*);
